FILE: hw/rtl/snfcs_pkg.sv
// Package for the SPI NOR flash command sequencer.
// Holds request and result payload types, codes and fixed command bytes.
// No dependencies.
package snfcs_pkg;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [22:0] address;
      logic [23:0] length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  spi_byte;
      logic        release_select;
      logic [7:0]  read_byte;
      logic [2:0]  status;
      logic [23:0] id_value;
      logic        last;
   } rsp_type;

   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_ERASE = 3'd2;
   localparam logic [2:0] OP_ID    = 3'd3;
   localparam logic [2:0] OP_WBYTE = 3'd4;
   localparam logic [2:0] OP_ECHO  = 3'd5;
   localparam logic [2:0] OP_TICK  = 3'd6;

   localparam logic [1:0] K_SPI   = 2'd0;
   localparam logic [1:0] K_RDATA = 2'd1;
   localparam logic [1:0] K_WREQ  = 2'd2;
   localparam logic [1:0] K_DONE  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ARG     = 3'd1;
   localparam logic [2:0] ST_STATE   = 3'd2;
   localparam logic [2:0] ST_NOSUP   = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_PTO   = 2'd1;
   localparam logic [1:0] CSR_ETO   = 2'd2;

   localparam logic [7:0] CMD_WREN = 8'h06;
   localparam logic [7:0] CMD_RDSR = 8'h05;
   localparam logic [7:0] CMD_READ = 8'h03;
   localparam logic [7:0] CMD_PP   = 8'h02;
   localparam logic [7:0] CMD_SE   = 8'h20;
   localparam logic [7:0] CMD_RDID = 8'h9F;
   localparam logic [7:0] DUMMY    = 8'hFF;

   localparam int QUEUE_DEPTH = 4;

endpackage

FILE: hw/rtl/snfcs_engine.sv
// Sequencer core: takes one request a cycle while go is high and produces up to two results.
// Depends on snfcs_pkg.
module snfcs_engine
   import snfcs_pkg::*;
#(
   parameter int CAPACITY_BYTES   = 8388608,
   parameter int PAGE_BYTES       = 256,
   parameter int SECTOR_BYTES     = 4096,
   parameter int READ_CHUNK_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  req_type     req,
   input  logic [1:0]  spi_mode,
   input  logic [15:0] prog_to,
   input  logic [15:0] erase_to,
   output logic [1:0]  n_out,
   output rsp_type     out0,
   output rsp_type     out1
);

   localparam logic [4:0] PH_IDLE = 5'd0, PH_RD_HDR = 5'd1, PH_RD_DATA = 5'd2,
      PH_ID = 5'd3, PH_POLL_CMD = 5'd4, PH_POLL_STAT = 5'd5, PH_POLL_WAIT = 5'd6,
      PH_WEN_CMD = 5'd7, PH_WEN_RS_CMD = 5'd8, PH_WEN_RS_STAT = 5'd9,
      PH_PP_HDR = 5'd10, PH_PP_REQ = 5'd11, PH_PP_DATA = 5'd12, PH_ER_HDR = 5'd13;

   localparam logic [24:0] CAP = 25'(CAPACITY_BYTES);
   localparam logic [24:0] SEC = 25'(SECTOR_BYTES);
   localparam logic [8:0]  PG  = 9'(PAGE_BYTES);
   localparam logic [8:0]  RCH = 9'(READ_CHUNK_BYTES);

   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic [22:0] addr_ff, addr_in;
   logic [23:0] left_ff, left_in;
   logic [8:0]  fidx_ff, fidx_in;
   logic [8:0]  chunk_ff, chunk_in;
   logic [15:0] ela_ff, ela_in;
   logic [23:0] id_ff, id_in;
   logic        after_ff, after_in;

   logic        mode_ok;
   logic [8:0]  fidx_p1;
   logic [8:0]  room;
   logic [8:0]  page_chunk;
   logic [15:0] limit;
   logic [24:0] a25, l25;

   assign mode_ok = (spi_mode == 2'd0) || (spi_mode == 2'd3);
   assign fidx_p1 = fidx_ff + 9'd1;
   assign limit   = (kind_ff == OP_ERASE[1:0]) ? erase_to : prog_to;
   assign a25 = {2'b00, req.address};
   assign l25 = {1'b0, req.length};

   function automatic logic [7:0] abyte(input logic [22:0] a, input logic [8:0] i);
      logic [23:0] w;
      w = {1'b0, a};
      if (i == 9'd1) return w[23:16];
      if (i == 9'd2) return w[15:8];
      return w[7:0];
   endfunction

   function automatic rsp_type mk(input logic [1:0] k, input logic [7:0] sb,
                                  input logic rel, input logic [7:0] rb,
                                  input logic [2:0] st, input logic [23:0] id);
      rsp_type r;
      r.kind = k; r.spi_byte = sb; r.release_select = rel; r.read_byte = rb;
      r.status = st; r.id_value = id; r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      room = PG - 9'(addr_ff % PAGE_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; kind_ff <= '0; addr_ff <= '0; left_ff <= '0;
         fidx_ff <= '0; chunk_ff <= '0; ela_ff <= '0; id_ff <= '0; after_ff <= 1'b0;
      end else if (go) begin
         phase_ff <= phase_in; kind_ff <= kind_in; addr_ff <= addr_in; left_ff <= left_in;
         fidx_ff <= fidx_in; chunk_ff <= chunk_in; ela_ff <= ela_in; id_ff <= id_in;
         after_ff <= after_in;
      end
   end

   always_comb begin
      logic [8:0]  proom;
      logic [22:0] na;
      logic [23:0] nl;
      logic [24:0] lenw;
      rsp_type     o[2];
      logic [1:0]  n;
      logic        dn;
      phase_in = phase_ff; kind_in = kind_ff; addr_in = addr_ff; left_in = left_ff;
      fidx_in = fidx_ff; chunk_in = chunk_ff; ela_in = ela_ff; id_in = id_ff;
      after_in = after_ff;
      o[0] = '0; o[1] = '0; n = 2'd0; dn = 1'b0;
      proom = '0; na = '0; nl = '0; lenw = '0;
      page_chunk = (left_ff < {15'd0, room}) ? left_ff[8:0] : room;
      unique case (req.opcode)
         OP_READ, OP_WRITE, OP_ERASE, OP_ID: begin
            if (phase_ff == PH_IDLE) begin
               kind_in = req.opcode[1:0]; addr_in = req.address; left_in = req.length;
               id_in = '0;
               lenw = (req.opcode == OP_ERASE) ? SEC : l25;
               if (req.opcode != OP_ID && (lenw == '0 || a25 >= CAP || lenw > CAP - a25
                   || (req.opcode == OP_ERASE && (req.address % SECTOR_BYTES) != 0))) begin
                  o[0] = mk(K_DONE, 0, 0, 0, ST_ARG, 0); n = 2'd1; phase_in = PH_IDLE;
               end else if (req.opcode == OP_READ) begin
                  if (!mode_ok) begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1;
                  end else begin
                     chunk_in = (req.length < {15'd0, RCH}) ? req.length[8:0] : RCH;
                     fidx_in = '0; o[0] = mk(K_SPI, CMD_READ, 0, 0, 0, 0); n = 2'd1;
                     phase_in = PH_RD_HDR;
                  end
               end else if (req.opcode == OP_ID) begin
                  if (!mode_ok) begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1;
                  end else begin
                     fidx_in = '0; o[0] = mk(K_SPI, CMD_RDID, 0, 0, 0, 0); n = 2'd1;
                     phase_in = PH_ID;
                  end
               end else begin
                  if (req.opcode == OP_WRITE) begin
                     proom = PG - 9'(req.address % PAGE_BYTES);
                     chunk_in = (req.length < {15'd0, proom}) ? req.length[8:0] : proom;
                  end
                  after_in = 1'b0; ela_in = '0;
                  if (!mode_ok) begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1; phase_in = PH_IDLE;
                  end else begin
                     o[0] = mk(K_SPI, CMD_RDSR, 0, 0, 0, 0); n = 2'd1; phase_in = PH_POLL_CMD;
                  end
               end
            end
         end
         OP_WBYTE: begin
            if (phase_ff == PH_PP_REQ) begin
               o[0] = mk(K_SPI, req.data_byte, fidx_p1 == chunk_ff, 0, 0, 0); n = 2'd1;
               phase_in = PH_PP_DATA;
            end
         end
         OP_TICK: begin
            if (phase_ff == PH_POLL_WAIT) begin
               if (ela_ff >= limit) begin
                  o[0] = mk(K_DONE, 0, 0, 0, ST_TIMEOUT, 0); n = 2'd1; phase_in = PH_IDLE;
               end else begin
                  ela_in = ela_ff + 16'd1;
                  if (!mode_ok) begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1; phase_in = PH_IDLE;
                  end else begin
                     o[0] = mk(K_SPI, CMD_RDSR, 0, 0, 0, 0); n = 2'd1; phase_in = PH_POLL_CMD;
                  end
               end
            end
         end
         OP_ECHO: begin
            case (phase_ff)
               PH_RD_HDR: begin
                  if (fidx_p1 <= 9'd3) begin
                     fidx_in = fidx_p1;
                     o[0] = mk(K_SPI, abyte(addr_ff, fidx_p1), 0, 0, 0, 0); n = 2'd1;
                  end else begin
                     fidx_in = '0;
                     o[0] = mk(K_SPI, DUMMY, chunk_ff == 9'd1, 0, 0, 0); n = 2'd1;
                     phase_in = PH_RD_DATA;
                  end
               end
               PH_RD_DATA: begin
                  o[0] = mk(K_RDATA, 0, 0, req.data_byte, 0, 0); n = 2'd1;
                  fidx_in = fidx_p1;
                  if (fidx_p1 < chunk_ff) begin
                     o[1] = mk(K_SPI, DUMMY, fidx_p1 + 9'd1 == chunk_ff, 0, 0, 0); n = 2'd2;
                  end else begin
                     na = addr_ff + 23'(chunk_ff); nl = left_ff - 24'(chunk_ff);
                     addr_in = na; left_in = nl;
                     if (nl == '0) begin
                        o[1] = mk(K_DONE, 0, 0, 0, ST_OK, 0); n = 2'd2; phase_in = PH_IDLE;
                     end else begin
                        chunk_in = (nl < {15'd0, RCH}) ? nl[8:0] : RCH;
                        fidx_in = '0;
                        o[1] = mk(K_SPI, CMD_READ, 0, 0, 0, 0); n = 2'd2;
                        phase_in = PH_RD_HDR;
                     end
                  end
               end
               PH_ID: begin
                  if (fidx_ff >= 9'd1) id_in = {id_ff[15:0], req.data_byte};
                  fidx_in = fidx_p1;
                  if (fidx_p1 < 9'd4) begin
                     o[0] = mk(K_SPI, DUMMY, fidx_p1 == 9'd3, 0, 0, 0); n = 2'd1;
                  end else begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_OK, id_in); n = 2'd1; phase_in = PH_IDLE;
                  end
               end
               PH_POLL_CMD: begin
                  o[0] = mk(K_SPI, DUMMY, 1'b1, 0, 0, 0); n = 2'd1; phase_in = PH_POLL_STAT;
               end
               PH_POLL_STAT: begin
                  if (req.data_byte[0]) begin
                     phase_in = PH_POLL_WAIT;
                  end else if (!after_ff) begin
                     if (!mode_ok) begin
                        o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1; phase_in = PH_IDLE;
                     end else begin
                        o[0] = mk(K_SPI, CMD_WREN, 1'b1, 0, 0, 0); n = 2'd1;
                        phase_in = PH_WEN_CMD;
                     end
                  end else if (kind_ff == OP_WRITE[1:0] && left_ff != '0) begin
                     chunk_in = page_chunk; after_in = 1'b0; ela_in = '0;
                     if (!mode_ok) begin
                        o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1; phase_in = PH_IDLE;
                     end else begin
                        o[0] = mk(K_SPI, CMD_RDSR, 0, 0, 0, 0); n = 2'd1;
                        phase_in = PH_POLL_CMD;
                     end
                  end else begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_OK, 0); n = 2'd1; phase_in = PH_IDLE;
                  end
               end
               PH_WEN_CMD: begin
                  if (!mode_ok) begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1; phase_in = PH_IDLE;
                  end else begin
                     o[0] = mk(K_SPI, CMD_RDSR, 0, 0, 0, 0); n = 2'd1; phase_in = PH_WEN_RS_CMD;
                  end
               end
               PH_WEN_RS_CMD: begin
                  o[0] = mk(K_SPI, DUMMY, 1'b1, 0, 0, 0); n = 2'd1; phase_in = PH_WEN_RS_STAT;
               end
               PH_WEN_RS_STAT: begin
                  if (!req.data_byte[1]) begin
                     o[0] = mk(K_DONE, 0, 0, 0, ST_STATE, 0); n = 2'd1; phase_in = PH_IDLE;
                  end else begin
                     fidx_in = '0; n = 2'd1;
                     if (kind_ff == OP_WRITE[1:0]) begin
                        o[0] = mk(K_SPI, CMD_PP, 0, 0, 0, 0); phase_in = PH_PP_HDR;
                     end else begin
                        o[0] = mk(K_SPI, CMD_SE, 0, 0, 0, 0); phase_in = PH_ER_HDR;
                     end
                  end
               end
               PH_PP_HDR: begin
                  if (fidx_p1 <= 9'd3) begin
                     fidx_in = fidx_p1;
                     o[0] = mk(K_SPI, abyte(addr_ff, fidx_p1), 0, 0, 0, 0); n = 2'd1;
                  end else begin
                     fidx_in = '0; o[0] = mk(K_WREQ, 0, 0, 0, 0, 0); n = 2'd1;
                     phase_in = PH_PP_REQ;
                  end
               end
               PH_PP_DATA: begin
                  fidx_in = fidx_p1;
                  if (fidx_p1 < chunk_ff) begin
                     o[0] = mk(K_WREQ, 0, 0, 0, 0, 0); n = 2'd1; phase_in = PH_PP_REQ;
                  end else begin
                     addr_in = addr_ff + 23'(chunk_ff); left_in = left_ff - 24'(chunk_ff);
                     dn = 1'b1;
                  end
               end
               PH_ER_HDR: begin
                  if (fidx_p1 <= 9'd3) begin
                     fidx_in = fidx_p1;
                     o[0] = mk(K_SPI, abyte(addr_ff, fidx_p1), fidx_p1 == 9'd3, 0, 0, 0);
                     n = 2'd1;
                  end else begin
                     fidx_in = fidx_p1; dn = 1'b1;
                  end
               end
               default: ;
            endcase
            if (dn) begin
               after_in = 1'b1; ela_in = '0;
               if (!mode_ok) begin
                  o[0] = mk(K_DONE, 0, 0, 0, ST_NOSUP, 0); n = 2'd1; phase_in = PH_IDLE;
               end else begin
                  o[0] = mk(K_SPI, CMD_RDSR, 0, 0, 0, 0); n = 2'd1; phase_in = PH_POLL_CMD;
               end
            end
         end
         default: ;
      endcase
      if (n == 2'd1) o[0].last = 1'b1;
      if (n == 2'd2) o[1].last = 1'b1;
      n_out = n; out0 = o[0]; out1 = o[1];
   end

endmodule

FILE: hw/rtl/snfcs_queue.sv
// Result queue between the sequencer core and the response port.
// Takes up to two results a cycle, hands out one. Depends on snfcs_pkg.
module snfcs_queue
   import snfcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] wr_n,
   input  rsp_type    wr0,
   input  rsp_type    wr1,
   output logic       room2,
   output logic       empty,
   input  logic       pop,
   output rsp_type    head
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   rsp_type       mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_pop;

   assign empty  = (cnt_ff == '0);
   assign do_pop = pop && !empty;
   assign room2  = (cnt_ff <= (AW+1)'(QUEUE_DEPTH - 2));
   assign head   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + AW'(wr_n);
      rp_in  = rp_ff + AW'(do_pop);
      cnt_in = cnt_ff + (AW+1)'(wr_n) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) mem_ff[wp_ff] <= wr0;
      if (wr_n == 2'd2) mem_ff[wp_ff + AW'(1)] <= wr1;
   end

endmodule

FILE: hw/rtl/spi_nor_flash_command_sequencer.sv
// SPI NOR flash command sequencer top level.
// A result is written into the result queue and appears in the cycle after the request that causes it.
// Throughput: one request per cycle while the result queue has room for two.
// Queue depth 4 sets the stall point. Reset is synchronous and active high;
// it idles the sequencer, empties the queue and restores register defaults.
module spi_nor_flash_command_sequencer
   import snfcs_pkg::*;
#(
   parameter int CAPACITY_BYTES   = 8388608,
   parameter int PAGE_BYTES       = 256,
   parameter int SECTOR_BYTES     = 4096,
   parameter int READ_CHUNK_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [1:0]  mode_ff;
   logic [15:0] pto_ff, eto_ff;
   logic        room2, go;
   logic [1:0]  n_raw, wr_n;
   rsp_type     o0, o1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0; pto_ff <= 16'd20; eto_ff <= 16'd1000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[1:0];
            CSR_PTO:  pto_ff  <= csr_wdata;
            CSR_ETO:  eto_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_full = !room2;
   assign go       = req_push && room2;
   assign wr_n     = go ? n_raw : 2'd0;

   snfcs_engine #(
      .CAPACITY_BYTES(CAPACITY_BYTES), .PAGE_BYTES(PAGE_BYTES),
      .SECTOR_BYTES(SECTOR_BYTES), .READ_CHUNK_BYTES(READ_CHUNK_BYTES)
   ) u_engine (
      .clock(clock), .reset(reset), .go(go), .req(req_data),
      .spi_mode(mode_ff), .prog_to(pto_ff), .erase_to(eto_ff),
      .n_out(n_raw), .out0(o0), .out1(o1)
   );

   snfcs_queue u_queue (
      .clock(clock), .reset(reset), .wr_n(wr_n), .wr0(o0), .wr1(o1),
      .room2(room2), .empty(rsp_empty), .pop(rsp_pop), .head(rsp_data)
   );

endmodule

FILE: hw/rtl/snfcs_checker.sv
// Port-level checker for the SPI NOR flash command sequencer, with its bind.
// Depends on snfcs_pkg.
module snfcs_checker
   import snfcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   a_rst_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("queue not empty after reset");
   a_rst_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("full after reset");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == K_DONE) |-> rsp_data.last)
      else $error("completion not last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("head changed without pop");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_checker (
   .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
);
